### rtl/core/cwfa_pkg.sv
// Package for the capped water-fill allocator.
// Holds sizes, opcodes, the sequencer state type and the headroom helper.
// Depends on nothing else.
package cwfa_pkg;

    localparam int SERVERS = 32;
    localparam int AW      = 20;
    localparam int MASK_W  = 32;
    localparam int IW      = $clog2(SERVERS);
    localparam int CW      = IW + 1;
    localparam int DW      = AW + CW;
    localparam int DCW     = $clog2(AW);

    localparam logic [2:0] OP_WR_LIMIT = 3'd0;
    localparam logic [2:0] OP_WR_COST  = 3'd1;
    localparam logic [2:0] OP_ALLOC    = 3'd2;
    localparam logic [2:0] OP_READ     = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_SHIFT,
        ST_TOP,
        ST_SUM,
        ST_TRIM,
        ST_DIVINIT,
        ST_DIV,
        ST_LEVEL,
        ST_FILL,
        ST_OVER,
        ST_EMIT,
        ST_EMPTY,
        ST_READ
    } state_t;

    function automatic logic [AW-1:0] headroom(input logic [AW-1:0] c,
                                               input logic [AW-1:0] l);
        return (c > l) ? (c - l) : '0;
    endfunction

endpackage

### rtl/core/capped_water_fill_allocator.sv
// Top level of the capped water-fill allocator.
// A single sequencer with one shared read port and one divider step.
// Depends on cwfa_pkg.

// Writes and clears are done in the idle state. A read waits in ST_READ for
// a free output register. An allocation request gathers the mask, sorts the
// usable servers by load with an insertion sort, sums the level, trims the
// set, divides bit-serially, fills each server, sorts again by headroom with
// a second insertion sort, spreads the overflow and emits the results.
// A new request may be taken while the previous result still waits in the
// output register.
module capped_water_fill_allocator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    opcode,
    input  logic [cwfa_pkg::IW-1:0]       server_index,
    input  logic [cwfa_pkg::AW-1:0]       amount_in,
    input  logic [cwfa_pkg::MASK_W-1:0]   server_mask,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cwfa_pkg::IW-1:0]       server_out,
    output logic [cwfa_pkg::AW-1:0]       granted,
    output logic [cwfa_pkg::AW-1:0]       load_after,
    output logic [cwfa_pkg::AW-1:0]       leftover,
    output logic                          status,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);
    import cwfa_pkg::*;

    state_t          state_reg, state_next;
    logic [AW-1:0]   load_reg  [SERVERS];
    logic [AW-1:0]   load_next [SERVERS];
    logic [AW-1:0]   limit_reg [SERVERS];
    logic [AW-1:0]   limit_next[SERVERS];
    logic [AW-1:0]   cost_reg  [SERVERS];
    logic [AW-1:0]   cost_next [SERVERS];
    logic [AW-1:0]   grant_reg [SERVERS];
    logic [AW-1:0]   grant_next[SERVERS];
    logic [IW-1:0]   list_reg  [SERVERS];
    logic [IW-1:0]   list_next [SERVERS];
    logic            cap_mode_reg;
    logic [SERVERS-1:0] mask_reg, mask_next;
    logic [CW-1:0]   n_reg, n_next, i_reg, i_next, j_reg, j_next, m_reg, m_next;
    logic [CW-1:0]   scan_reg, scan_next, less_reg, less_next, rem_reg, rem_next;
    logic            pass_reg, pass_next;
    logic [IW-1:0]   v_reg, v_next, idx_reg, idx_next;
    logic [AW-1:0]   vkey_reg, vkey_next, demand_reg, demand_next, top_reg, top_next;
    logic [AW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   dif_reg, dif_next;
    logic [DCW-1:0]  dcnt_reg, dcnt_next;
    logic [AW:0]     left_reg, left_next, level_reg, level_next;
    logic            out_valid_reg, out_valid_next;
    logic [IW-1:0]   server_out_reg, server_out_next;
    logic [AW-1:0]   granted_reg, granted_next, load_after_reg, load_after_next;
    logic [AW-1:0]   leftover_reg, leftover_next;
    logic            status_reg, status_next, last_reg, last_next;

    logic [IW-1:0]   ra;
    logic [AW-1:0]   rload, rcap, rhead;
    logic [SERVERS-1:0] gnz;
    logic [CW-1:0]   nm1, im1, jm1;

    assign nm1 = n_reg - 1'b1;
    assign im1 = i_reg - 1'b1;
    assign jm1 = j_reg - 1'b1;

    always_comb
    begin
        case (state_reg)
            ST_READ:  ra = idx_reg;
            ST_SHIFT: ra = list_reg[jm1[IW-1:0]];
            ST_TOP:   ra = list_reg[nm1[IW-1:0]];
            ST_TRIM:  ra = list_reg[im1[IW-1:0]];
            default:  ra = list_reg[i_reg[IW-1:0]];
        endcase
    end

    assign rload = load_reg[ra];
    assign rcap  = cap_mode_reg ? cost_reg[ra] : limit_reg[ra];
    assign rhead = headroom(rcap, rload);

    always_comb
    begin
        for (int k = 0; k < SERVERS; k++)
        begin
            gnz[k] = (grant_reg[k] != '0);
        end
    end

    always_comb
    begin
        logic [AW-1:0]      kp;
        logic               mv;
        logic [DW-1:0]      prod;
        logic [CW-1:0]      trial;
        logic [AW:0]        target, capx, nl, hx;
        logic [AW-1:0]      g;
        logic [SERVERS-1:0] rest;
        logic               out_free;

        state_next      = state_reg;
        load_next       = load_reg;
        limit_next      = limit_reg;
        cost_next       = cost_reg;
        grant_next      = grant_reg;
        list_next       = list_reg;
        mask_next       = mask_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        m_next          = m_reg;
        scan_next       = scan_reg;
        less_next       = less_reg;
        rem_next        = rem_reg;
        pass_next       = pass_reg;
        v_next          = v_reg;
        idx_next        = idx_reg;
        vkey_next       = vkey_reg;
        demand_next     = demand_reg;
        top_next        = top_reg;
        quo_next        = quo_reg;
        dif_next        = dif_reg;
        dcnt_next       = dcnt_reg;
        left_next       = left_reg;
        level_next      = level_reg;
        server_out_next = server_out_reg;
        granted_next    = granted_reg;
        load_after_next = load_after_reg;
        leftover_next   = leftover_reg;
        status_next     = status_reg;
        last_next       = last_reg;

        out_free       = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;

        kp     = '0;
        mv     = 1'b0;
        prod   = '0;
        trial  = '0;
        target = '0;
        capx   = '0;
        nl     = '0;
        hx     = '0;
        g      = '0;
        rest   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (opcode)
                        OP_WR_LIMIT:
                        begin
                            if ({1'b0, server_index} < CW'(SERVERS))
                                limit_next[server_index] = amount_in;
                        end
                        OP_WR_COST:
                        begin
                            if ({1'b0, server_index} < CW'(SERVERS))
                                cost_next[server_index] = amount_in;
                        end
                        OP_ALLOC:
                        begin
                            demand_next = amount_in;
                            mask_next   = server_mask[SERVERS-1:0];
                            n_next      = '0;
                            i_next      = '0;
                            for (int k = 0; k < SERVERS; k++)
                            begin
                                grant_next[k] = '0;
                            end
                            state_next  = ST_SCAN;
                        end
                        OP_READ:
                        begin
                            idx_next   = server_index;
                            state_next = ST_READ;
                        end
                        OP_CLEAR:
                        begin
                            for (int k = 0; k < SERVERS; k++)
                            begin
                                load_next[k] = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    server_out_next = idx_reg;
                    granted_next    = '0;
                    load_after_next = rload;
                    leftover_next   = '0;
                    status_next     = 1'b0;
                    last_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (mask_reg[i_reg[IW-1:0]])
                begin
                    list_next[n_reg[IW-1:0]] = i_reg[IW-1:0];
                    n_next = n_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
                if (i_reg == CW'(SERVERS - 1))
                begin
                    if (n_next == '0)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        pass_next  = 1'b0;
                        i_next     = CW'(1);
                        state_next = ST_PICK;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    server_out_next = '0;
                    granted_next    = '0;
                    load_after_next = '0;
                    leftover_next   = demand_reg;
                    status_next     = 1'b1;
                    last_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_PICK:
            begin
                if (i_reg >= n_reg)
                begin
                    if (!pass_reg)
                    begin
                        state_next = ST_TOP;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = ST_OVER;
                    end
                end
                else
                begin
                    v_next     = ra;
                    vkey_next  = pass_reg ? rhead : rload;
                    j_next     = i_reg;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                kp = pass_reg ? rhead : rload;
                if (pass_reg)
                    mv = (kp < vkey_reg) || ((kp == vkey_reg) && (ra > v_reg));
                else
                    mv = (kp > vkey_reg);
                if ((j_reg != '0) && mv)
                begin
                    list_next[j_reg[IW-1:0]] = ra;
                    j_next = jm1;
                end
                else
                begin
                    list_next[j_reg[IW-1:0]] = v_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_PICK;
                end
            end
            ST_TOP:
            begin
                top_next   = rload;
                dif_next   = '0;
                i_next     = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                dif_next = dif_reg + DW'(top_reg - rload);
                if (i_reg == nm1)
                begin
                    m_next     = n_reg;
                    state_next = ST_TRIM;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_TRIM:
            begin
                if ((i_reg == '0) || (dif_reg <= DW'(demand_reg)))
                begin
                    state_next = ST_DIVINIT;
                end
                else
                begin
                    prod     = DW'(top_reg - rload) * DW'(m_reg - 1'b1);
                    dif_next = dif_reg - prod;
                    top_next = rload;
                    m_next   = m_reg - 1'b1;
                    i_next   = im1;
                end
            end
            ST_DIVINIT:
            begin
                quo_next   = demand_reg - dif_reg[AW-1:0];
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                trial = {rem_reg[CW-2:0], quo_reg[AW-1]};
                if (trial >= m_reg)
                begin
                    rem_next = trial - m_reg;
                    quo_next = {quo_reg[AW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[AW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(AW - 1))
                    state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                level_next = {1'b0, top_reg} + {1'b0, quo_reg};
                less_next  = m_reg - rem_reg;
                i_next     = '0;
                left_next  = '0;
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                target = level_reg + ((i_reg >= less_reg) ? (AW+1)'(1) : (AW+1)'(0));
                capx   = {1'b0, rcap};
                nl     = (target <= capx) ? target : capx;
                if (nl < {1'b0, rload})
                    nl = {1'b0, rload};
                left_next      = left_reg + (target - nl);
                grant_next[ra] = grant_reg[ra] + (nl[AW-1:0] - rload);
                load_next[ra]  = nl[AW-1:0];
                if (i_reg == m_reg - 1'b1)
                begin
                    pass_next  = 1'b1;
                    i_next     = CW'(1);
                    state_next = ST_PICK;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_OVER:
            begin
                if ((i_reg == n_reg) || (left_reg == '0))
                begin
                    scan_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    hx             = {1'b0, rhead};
                    g              = (hx >= left_reg) ? left_reg[AW-1:0] : rhead;
                    load_next[ra]  = rload + g;
                    grant_next[ra] = grant_reg[ra] + g;
                    left_next      = left_reg - {1'b0, g};
                    i_next         = i_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (gnz == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        server_out_next = '0;
                        granted_next    = '0;
                        load_after_next = '0;
                        leftover_next   = left_reg[AW-1:0];
                        status_next     = 1'b0;
                        last_next       = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (scan_reg == CW'(SERVERS))
                begin
                    state_next = ST_IDLE;
                end
                else if (gnz[scan_reg[IW-1:0]])
                begin
                    if (out_free)
                    begin
                        rest            = gnz >> scan_reg[IW-1:0];
                        out_valid_next  = 1'b1;
                        server_out_next = scan_reg[IW-1:0];
                        granted_next    = grant_reg[scan_reg[IW-1:0]];
                        load_after_next = load_reg[scan_reg[IW-1:0]];
                        last_next       = ((rest >> 1) == '0);
                        leftover_next   = last_next ? left_reg[AW-1:0] : '0;
                        status_next     = 1'b0;
                        scan_next       = scan_reg + 1'b1;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SERVERS; k++)
            begin
                load_reg[k]  <= '0;
                limit_reg[k] <= '0;
                cost_reg[k]  <= '0;
                grant_reg[k] <= '0;
            end
            n_reg    <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            m_reg    <= '0;
            scan_reg <= '0;
            dcnt_reg <= '0;
            pass_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                cap_mode_reg <= cfg_data;
            load_reg  <= load_next;
            limit_reg <= limit_next;
            cost_reg  <= cost_next;
            grant_reg <= grant_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            m_reg     <= m_next;
            scan_reg  <= scan_next;
            dcnt_reg  <= dcnt_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg       <= list_next;
        mask_reg       <= mask_next;
        less_reg       <= less_next;
        rem_reg        <= rem_next;
        v_reg          <= v_next;
        idx_reg        <= idx_next;
        vkey_reg       <= vkey_next;
        demand_reg     <= demand_next;
        top_reg        <= top_next;
        quo_reg        <= quo_next;
        dif_reg        <= dif_next;
        left_reg       <= left_next;
        level_reg      <= level_next;
        server_out_reg <= server_out_next;
        granted_reg    <= granted_next;
        load_after_reg <= load_after_next;
        leftover_reg   <= leftover_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign server_out = server_out_reg;
    assign granted    = granted_reg;
    assign load_after = load_after_reg;
    assign leftover   = leftover_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last)
        else $error("error status on a result that is not the last");

    a_leftover_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> leftover == '0)
        else $error("leftover set on a result that is not the last");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> m_reg != '0)
        else $error("divider started with a zero server count");

    a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status && granted == '0 |-> last)
        else $error("zero grant emitted as a per-server result");

endmodule

### bench/cwfa_checker.sv
`timescale 1ns / 100ps
// Checker for the capped water-fill allocator: watches the request, result and
// configuration channels, predicts every result and compares. Depends on cwfa_pkg.
module cwfa_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [2:0]                  opcode,
    input  logic [cwfa_pkg::IW-1:0]     server_index,
    input  logic [cwfa_pkg::AW-1:0]     amount_in,
    input  logic [cwfa_pkg::MASK_W-1:0] server_mask,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [cwfa_pkg::IW-1:0]     server_out,
    input  logic [cwfa_pkg::AW-1:0]     granted,
    input  logic [cwfa_pkg::AW-1:0]     load_after,
    input  logic [cwfa_pkg::AW-1:0]     leftover,
    input  logic                        status,
    input  logic                        last,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic                        cfg_data,
    output int                          fail_count,
    output int                          pending
);
    import cwfa_pkg::*;

    typedef struct packed {
        logic [IW-1:0] srv;
        logic [AW-1:0] grant;
        logic [AW-1:0] load;
        logic [AW-1:0] left;
        logic          stat;
        logic          fin;
    } grant_rec_t;

    grant_rec_t    grants_due[$];
    logic [AW-1:0] load_m  [SERVERS];
    logic [AW-1:0] limit_m [SERVERS];
    logic [AW-1:0] cost_m  [SERVERS];
    logic          mode_m;

    function automatic longint unsigned cap_of(int s);
        return mode_m ? cost_m[s] : limit_m[s];
    endfunction

    function automatic longint unsigned room_of(int s);
        return (cap_of(s) > load_m[s]) ? cap_of(s) - load_m[s] : 0;
    endfunction

    function automatic grant_rec_t mk(int s, longint unsigned g, longint unsigned l,
                                      longint unsigned lo, logic st, logic f);
        grant_rec_t r;
        r.srv = s[IW-1:0];
        r.grant = g[AW-1:0];
        r.load = l[AW-1:0];
        r.left = lo[AW-1:0];
        r.stat = st;
        r.fin = f;
        return r;
    endfunction

    task automatic predict_alloc(longint unsigned demand, logic [MASK_W-1:0] mask);
        int lst[SERVERS];
        longint unsigned gr[SERVERS];
        int n, i, j, v, k, s;
        longint unsigned top, dif, m, spare, level, less, left, target, nl, h, g;
        grant_rec_t r;
        n = 0;
        for (i = 0; i < SERVERS; i++)
        begin
            gr[i] = 0;
            if (mask[i])
            begin
                lst[n] = i;
                n++;
            end
        end
        if (n == 0)
        begin
            grants_due.push_back(mk(0, 0, 0, demand, 1'b1, 1'b1));
            return;
        end
        for (i = 1; i < n; i++)
        begin
            v = lst[i];
            j = i;
            while (j > 0 && load_m[lst[j-1]] > load_m[v])
            begin
                lst[j] = lst[j-1];
                j--;
            end
            lst[j] = v;
        end
        top = load_m[lst[n-1]];
        dif = 0;
        for (i = 0; i < n; i++)
            dif += top - load_m[lst[i]];
        m = n;
        for (i = n - 1; i > 0; i--)
        begin
            if (dif <= demand)
                break;
            dif -= (longint'(load_m[lst[i]]) - load_m[lst[i-1]]) * (m - 1);
            top = load_m[lst[i-1]];
            m--;
        end
        spare = demand - dif;
        level = top + spare / m;
        less = m - spare % m;
        left = 0;
        for (i = 0; i < int'(m); i++)
        begin
            s = lst[i];
            target = level + ((i < less) ? 0 : 1);
            nl = (target <= cap_of(s)) ? target : cap_of(s);
            if (nl < load_m[s])
                nl = load_m[s];
            left += target - nl;
            gr[s] += nl - load_m[s];
            load_m[s] = nl[AW-1:0];
        end
        for (i = 1; i < n; i++)
        begin
            v = lst[i];
            j = i;
            while (j > 0 && (room_of(lst[j-1]) < room_of(v) ||
                   (room_of(lst[j-1]) == room_of(v) && lst[j-1] > v)))
            begin
                lst[j] = lst[j-1];
                j--;
            end
            lst[j] = v;
        end
        for (i = 0; i < n && left != 0; i++)
        begin
            s = lst[i];
            h = room_of(s);
            g = (h >= left) ? left : h;
            load_m[s] = load_m[s] + g[AW-1:0];
            gr[s] += g;
            left -= g;
        end
        k = 0;
        for (i = 0; i < SERVERS; i++)
        begin
            if (gr[i] != 0)
            begin
                grants_due.push_back(mk(i, gr[i], load_m[i], 0, 1'b0, 1'b0));
                k++;
            end
        end
        if (k == 0)
        begin
            grants_due.push_back(mk(0, 0, 0, left, 1'b0, 1'b1));
        end
        else
        begin
            r = grants_due.pop_back();
            r.left = left[AW-1:0];
            r.fin = 1'b1;
            grants_due.push_back(r);
        end
    endtask

    initial
    begin
        fail_count = 0;
        mode_m = 1'b0;
        for (int i = 0; i < SERVERS; i++)
        begin
            load_m[i] = '0;
            limit_m[i] = '0;
            cost_m[i] = '0;
        end
    end

    assign pending = grants_due.size();

    always @(posedge clk)
    begin
        grant_rec_t e, a;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                mode_m <= cfg_data;
            if (in_valid && !in_stall)
            begin
                case (opcode)
                    OP_WR_LIMIT: limit_m[server_index] = amount_in;
                    OP_WR_COST:  cost_m[server_index] = amount_in;
                    OP_ALLOC:    predict_alloc(amount_in, server_mask);
                    OP_READ:     grants_due.push_back(mk(server_index, 0,
                                     load_m[server_index], 0, 1'b0, 1'b1));
                    OP_CLEAR:    for (int i = 0; i < SERVERS; i++) load_m[i] = '0;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                a = mk(server_out, granted, load_after, leftover, status, last);
                if (grants_due.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, a);
                    fail_count++;
                end
                else
                begin
                    e = grants_due.pop_front();
                    if (e != a)
                    begin
                        $display("%0t: mismatch expected srv=%0d grant=%0d load=%0d left=%0d st=%0b last=%0b",
                                 $time, e.srv, e.grant, e.load, e.left, e.stat, e.fin);
                        $display("%0t:          actual   srv=%0d grant=%0d load=%0d left=%0d st=%0b last=%0b",
                                 $time, a.srv, a.grant, a.load, a.left, a.stat, a.fin);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

### bench/tb_capped_water_fill_allocator.sv
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, directed and random requests,
// configuration phases and the verdict. Depends on cwfa_pkg, cwfa_checker and the allocator.
module tb_capped_water_fill_allocator;
    import cwfa_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic              clk, rst_n;
    logic              in_valid, in_stall, out_valid, out_stall;
    logic [2:0]        opcode;
    logic [IW-1:0]     server_index, server_out;
    logic [AW-1:0]     amount_in, granted, load_after, leftover;
    logic [MASK_W-1:0] server_mask;
    logic              status, last, cfg_valid, cfg_ready, cfg_data;
    logic              in_stall_q, cfg_ready_q;
    int                fail_count, pending;
    bit                quiet, hold_req, hold_used;
    int                hold_left;

    capped_water_fill_allocator uut (.*);
    cwfa_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    always @(negedge clk)
    begin
        in_stall_q = in_stall;
        cfg_ready_q = cfg_ready;
    end

    always @(posedge clk)
    begin
        if (hold_req && !hold_used && hold_left == 0)
        begin
            hold_used <= 1'b1;
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < 12);
    end

    task automatic send_req(logic [2:0] op, logic [IW-1:0] idx, logic [AW-1:0] amt,
                            logic [MASK_W-1:0] mask);
        opcode <= op;
        server_index <= idx;
        amount_in <= amt;
        server_mask <= mask;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall_q)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic set_mode(logic v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready_q)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int done, pick;
        logic [MASK_W-1:0] mask;
        logic [AW-1:0] amt;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(0, 99);
            quiet = (done > count / 3) && (done < count / 3 + 40);
            hold_req = (done == count / 2);
            amt = ($urandom_range(0, 9) == 0) ? AW'($urandom) : AW'($urandom_range(0, 6000));
            mask = $urandom;
            case ($urandom_range(0, 3))
                0: mask = mask & $urandom;
                1: mask = mask & $urandom & $urandom;
                2: mask = 32'h1 << $urandom_range(0, 31);
                default: ;
            endcase
            if (pick < 16)
                send_req(OP_WR_LIMIT, $urandom, amt, $urandom);
            else if (pick < 32)
                send_req(OP_WR_COST, $urandom, amt, $urandom);
            else if (pick < 84)
                send_req(OP_ALLOC, $urandom, amt, mask);
            else if (pick < 95)
                send_req(OP_READ, $urandom, $urandom, $urandom);
            else if (pick < 97)
                send_req(OP_CLEAR, $urandom, $urandom, $urandom);
            else
                send_req(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom, $urandom,
                         $urandom);
            if (pick < 97)
                done++;
        end
        quiet = 1'b0;
        hold_req = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        opcode <= OP_WR_LIMIT;
        server_index <= '0;
        amount_in <= '0;
        server_mask <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= 1'b0;
        out_stall <= 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        set_mode(1'b0);

        send_req(OP_ALLOC, 0, 20'hFFFFF, '0);
        send_req(OP_ALLOC, 0, 0, '1);
        send_req(OP_ALLOC, 0, 100, '1);
        send_req(OP_WR_LIMIT, 0, 20'hFFFFF, '0);
        send_req(OP_WR_LIMIT, 31, 20'hFFFFF, '0);
        send_req(OP_WR_LIMIT, 5, 10, '0);
        send_req(OP_WR_COST, 0, 5, '0);
        send_req(OP_WR_COST, 31, 0, '0);
        send_req(OP_ALLOC, 0, 20'hFFFFF, 32'h8000_0021);
        send_req(OP_ALLOC, 0, 7, 32'h8000_0021);
        send_req(OP_READ, 0, 0, '0);
        send_req(OP_READ, 31, 0, '0);
        send_req(OP_READ, 5, 0, '0);
        send_req(OP_SPARE_LO, 3, 9, '1);
        send_req(OP_SPARE_HI, 3, 9, '1);
        set_mode(1'b1);
        send_req(OP_ALLOC, 0, 50, 32'h8000_0021);
        send_req(OP_WR_COST, 5, 30, '0);
        send_req(OP_ALLOC, 0, 1000, '1);
        send_req(OP_CLEAR, 0, 0, '0);
        send_req(OP_READ, 31, 0, '0);
        send_req(OP_ALLOC, 0, 13, 32'h0000_0021);

        random_phase(140);
        set_mode(1'b0);
        random_phase(140);
        set_mode(1'b1);
        random_phase(140);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (1500) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
